[sv/sws_pkg.sv]
`timescale 1ns / 1ps
package sws_pkg;

	localparam int PHASE_BITS    = 32;
	localparam int OUTPUT_BITS   = 16;
	localparam int CORDIC_STAGES = 16;

	localparam int AMP_BITS   = 15;
	localparam int COUNT_BITS = 24;
	localparam int CFG_BITS   = 32;
	localparam int DATA_BITS  = 32;
	localparam int SHIFT_BITS = 5;

	localparam int PHASE_DN = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
	localparam int PHASE_UP = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic signed [DATA_BITS-1:0] CORDIC_INIT_X = 32'sd652032874;

	localparam logic signed [31:0] SAMPLE_MAX = 32'sd2 ** (OUTPUT_BITS - 1) - 32'sd1;
	localparam logic signed [31:0] SAMPLE_MIN = -SAMPLE_MAX - 32'sd1;

	typedef enum logic [1:0] {
		CFG_PHASE_STEP   = 2'd0,
		CFG_AMPLITUDE    = 2'd1,
		CFG_SAMPLE_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] x;
		logic signed [DATA_BITS-1:0] y;
		logic signed [DATA_BITS-1:0] z;
		logic [1:0]                  quad;
		logic                        last;
	} cordic_t;

	function automatic logic signed [DATA_BITS-1:0] atan_q30(input int i);
		logic signed [DATA_BITS-1:0] a;
		case (i)
			0:       a = 32'sd843314857;
			1:       a = 32'sd497837829;
			2:       a = 32'sd263043837;
			3:       a = 32'sd133525159;
			4:       a = 32'sd67021687;
			5:       a = 32'sd33543516;
			6:       a = 32'sd16775851;
			7:       a = 32'sd8388437;
			8:       a = 32'sd4194283;
			9:       a = 32'sd2097149;
			10:      a = 32'sd1048576;
			11:      a = 32'sd524288;
			12:      a = 32'sd262144;
			13:      a = 32'sd131072;
			14:      a = 32'sd65536;
			15:      a = 32'sd32768;
			16:      a = 32'sd16384;
			17:      a = 32'sd8192;
			18:      a = 32'sd4096;
			19:      a = 32'sd2048;
			20:      a = 32'sd1024;
			21:      a = 32'sd512;
			22:      a = 32'sd256;
			default: a = 32'sd128;
		endcase
		return a;
	endfunction

endpackage

[sv/sws_front.sv]
`timescale 1ns / 1ps
module sws_front import sws_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PHASE_BITS-1:0] phase_step,
	input  logic [COUNT_BITS-1:0] sample_count,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cordic_t               out_data
);

	logic [PHASE_BITS-1:0] phase_q;
	logic [COUNT_BITS-1:0] index_q;
	logic                  valid_s1;
	cordic_t               data_s1;

	logic [PHASE_BITS-1:0] phase_eff;
	logic [COUNT_BITS-1:0] index_eff;
	logic                  live;
	logic                  last_d;
	logic [63:0]           phase_wide;
	logic [31:0]           p32;
	logic [60:0]           angle_prod;
	logic                  xfer;

	always_comb begin
		phase_eff  = restart ? '0 : phase_q;
		index_eff  = restart ? '0 : index_q;
		live       = index_eff < sample_count;
		last_d     = ({1'b0, index_eff} + 25'd1) == {1'b0, sample_count};
		phase_wide = 64'(phase_eff);
		p32        = 32'((phase_wide >> PHASE_DN) << PHASE_UP);
		angle_prod = 61'(p32[29:0]) * 61'(HALF_PI_Q30);
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign xfer      = in_valid && in_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			index_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= xfer && live;
			if (xfer) begin
				if (live) begin
					phase_q <= phase_eff + phase_step;
					index_q <= index_eff + 24'd1;
				end else begin
					phase_q <= phase_eff;
					index_q <= index_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && live) begin
			data_s1.x    <= CORDIC_INIT_X;
			data_s1.y    <= '0;
			data_s1.z    <= $signed(32'(angle_prod >> 30));
			data_s1.quad <= p32[31:30];
			data_s1.last <= last_d;
		end
	end

endmodule

[sv/sws_cordic_cell.sv]
`timescale 1ns / 1ps
module sws_cordic_cell import sws_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [SHIFT_BITS-1:0]       shamt,
	input  logic signed [DATA_BITS-1:0] angle,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cordic_t                     in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cordic_t                     out_data
);

	logic    valid_q;
	cordic_t data_q;
	cordic_t next_d;
	logic signed [DATA_BITS-1:0] dx;
	logic signed [DATA_BITS-1:0] dy;

	always_comb begin
		dx     = in_data.y >>> shamt;
		dy     = in_data.x >>> shamt;
		next_d = in_data;
		if (!in_data.z[DATA_BITS-1]) begin
			next_d.x = in_data.x - dx;
			next_d.y = in_data.y + dy;
			next_d.z = in_data.z - angle;
		end else begin
			next_d.x = in_data.x + dx;
			next_d.y = in_data.y - dy;
			next_d.z = in_data.z + angle;
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			data_q <= next_d;
	end

endmodule

[sv/sws_back.sv]
`timescale 1ns / 1ps
module sws_back import sws_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [AMP_BITS-1:0]           amplitude,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cordic_t                       in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [OUTPUT_BITS-1:0] sample,
	output logic                          last
);

	logic               valid_s1, valid_s2, valid_q;
	logic signed [15:0] sine_s1;
	logic               last_s1;
	logic signed [31:0] prod_s2;
	logic               last_s2;
	logic signed [OUTPUT_BITS-1:0] sample_q;
	logic               last_q;

	logic               ready_s1, ready_s2, ready_q;
	logic signed [31:0] s_full, c_full, pick;
	logic signed [15:0] sine_d;
	logic signed [31:0] prod_d;
	logic signed [31:0] shifted;
	logic signed [31:0] sat;

	always_comb begin
		s_full = (in_data.y + 32'sd16384) >>> 15;
		c_full = (in_data.x + 32'sd16384) >>> 15;
		case (in_data.quad)
			2'd0:    pick = s_full;
			2'd1:    pick = c_full;
			2'd2:    pick = -s_full;
			default: pick = -c_full;
		endcase
		if (pick > 32'sd32767)
			sine_d = 16'sd32767;
		else if (pick < -32'sd32767)
			sine_d = -16'sd32767;
		else
			sine_d = 16'(pick);

		prod_d  = $signed({1'b0, amplitude}) * sine_s1;
		shifted = prod_s2 >>> 15;
		if (shifted > SAMPLE_MAX)
			sat = SAMPLE_MAX;
		else if (shifted < SAMPLE_MIN)
			sat = SAMPLE_MIN;
		else
			sat = shifted;
	end

	assign ready_q   = !valid_q || out_ready;
	assign ready_s2  = !valid_s2 || ready_q;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = valid_q;
	assign sample    = sample_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_q)
				valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			sine_s1 <= sine_d;
			last_s1 <= in_data.last;
		end
		if (valid_s1 && ready_s2) begin
			prod_s2 <= prod_d;
			last_s2 <= last_s1;
		end
		if (valid_s2 && ready_q) begin
			sample_q <= OUTPUT_BITS'(sat);
			last_q   <= last_s2;
		end
	end

endmodule

[sv/sine_wave_synthesizer_top.sv]
`timescale 1ns / 1ps
// Direct digital sine synthesizer. Each tick transfer with a result yields one sample,
// amplitude * sin(2*pi*phase/2^32), then advances the phase by phase_step; once
// sample_count samples have gone out, ticks are taken without a result until restart.
// restart zeroes phase and sample index ahead of that tick's sample. One tick per clock
// while the output is not stalled. The pipeline is the phase/angle stage, the chain of
// CORDIC rotation cells and the round, amplitude-multiply and saturate stages.
// Each stage has its own skid-free valid/ready register, so bubbles collapse under stall.
// Configuration writes are taken every cycle and must only occur while the block is idle.
module sine_wave_synthesizer_top import sws_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [CFG_BITS-1:0]           cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [OUTPUT_BITS-1:0] sample,
	output logic                          last
);

	logic [PHASE_BITS-1:0] phase_step_q;
	logic [AMP_BITS-1:0]   amplitude_q;
	logic [COUNT_BITS-1:0] sample_count_q;

	cordic_t chain_data  [CORDIC_STAGES+1];
	logic    chain_valid [CORDIC_STAGES+1];
	logic    chain_ready [CORDIC_STAGES+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= '0;
			amplitude_q    <= '0;
			sample_count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PHASE_STEP:   phase_step_q   <= PHASE_BITS'(cfg_data);
				CFG_AMPLITUDE:    amplitude_q    <= cfg_data[AMP_BITS-1:0];
				CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	sws_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.phase_step   (phase_step_q),
		.sample_count (sample_count_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (chain_valid[0]),
		.out_ready    (chain_ready[0]),
		.out_data     (chain_data[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		sws_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shamt     (SHIFT_BITS'(i)),
			.angle     (atan_q30(i)),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	sws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.amplitude (amplitude_q),
		.in_valid  (chain_valid[CORDIC_STAGES]),
		.in_ready  (chain_ready[CORDIC_STAGES]),
		.in_data   (chain_data[CORDIC_STAGES]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.last      (last)
	);

endmodule

[verif/sine_wave_synthesizer_top_test.sv]
`timescale 1ns / 1ps
module sine_wave_synthesizer_top_test;
	import sws_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int SETTLE = 1 + CORDIC_STAGES + 3 + 8;
	localparam int HOLD_OFF = 200;
	localparam int RANDOM_TICKS = 1250;
	localparam int END_LIMIT = 20000;
	localparam int RUN_LIMIT_NS = 3000000;

	typedef struct packed {
		logic [OUTPUT_BITS-1:0] value;
		logic                   last;
	} sample_t;

	typedef struct packed {
		bit                     is_cfg;
		logic [1:0]             idx;
		logic [CFG_BITS-1:0]    data;
		bit                     rst;
		bit                     pinned;
		bit                     pin_valid;
		logic [OUTPUT_BITS-1:0] pin_value;
		bit                     pin_last;
	} script_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index;
	logic [CFG_BITS-1:0]           cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic                          restart;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [OUTPUT_BITS-1:0] sample;
	logic                          last;

	// tone generator state as seen by the predictor
	logic [PHASE_BITS-1:0] step_reg;
	logic [AMP_BITS-1:0]   amp_reg;
	logic [COUNT_BITS-1:0] count_reg;
	logic [PHASE_BITS-1:0] phase_acc;
	logic [COUNT_BITS-1:0] sample_idx;

	longint arctan_q30 [0:15] = '{
		843314857, 497837829, 263043837, 133525159,
		67021687, 33543516, 16775851, 8388437,
		4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768
	};

	sample_t     pending_samples[$];
	script_row_t script[$];
	sample_t     head;
	bit          calm;
	bit          held;
	bit          squeeze;
	int          faults;
	int          samples_due;
	int          samples_checked;
	int          lasts_seen;
	int          ticks_sent;
	int          restarts;
	int          cfg_writes;

	sine_wave_synthesizer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint cordic_sine(input logic [31:0] ph);
		longint unsigned angle;
		longint x, y, z, dx, dy, s, c, v;
		angle = 64'(ph[29:0]) * 64'(HALF_PI_Q30);
		z = longint'(angle >> 30);
		x = longint'(CORDIC_INIT_X);
		y = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_q30[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_q30[i];
			end
		end
		s = (y + 16384) >>> 15;
		c = (x + 16384) >>> 15;
		case (ph[31:30])
			2'd0: v = s;
			2'd1: v = c;
			2'd2: v = -s;
			default: v = -c;
		endcase
		if (v > 32767) v = 32767;
		if (v < -32767) v = -32767;
		return v;
	endfunction

	function automatic void predict_tick(input bit rst, output bit got, output sample_t s);
		longint prod;
		s = '0;
		got = 1'b0;
		if (rst) begin
			phase_acc = '0;
			sample_idx = '0;
		end
		if (sample_idx >= count_reg) return;
		prod = (longint'(amp_reg) * cordic_sine(phase_acc)) >>> 15;
		if (prod > SAMPLE_MAX) prod = SAMPLE_MAX;
		if (prod < SAMPLE_MIN) prod = SAMPLE_MIN;
		got = 1'b1;
		s.value = prod[OUTPUT_BITS-1:0];
		s.last = (sample_idx + 1'b1 == count_reg);
		sample_idx = sample_idx + 1'b1;
		phase_acc = phase_acc + step_reg;
	endfunction

	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic void add_cfg(input logic [1:0] idx, input logic [CFG_BITS-1:0] data);
		script_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = data;
		script.push_back(row);
	endfunction

	function automatic void add_tick(input bit rst);
		script_row_t row;
		row = '0;
		row.rst = rst;
		script.push_back(row);
	endfunction

	function automatic void add_known(input bit rst, input bit got,
			input logic [OUTPUT_BITS-1:0] value, input bit is_last);
		script_row_t row;
		row = '0;
		row.rst = rst;
		row.pinned = 1'b1;
		row.pin_valid = got;
		row.pin_value = value;
		row.pin_last = is_last;
		script.push_back(row);
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PHASE_STEP: step_reg = data[PHASE_BITS-1:0];
			CFG_AMPLITUDE: amp_reg = data[AMP_BITS-1:0];
			CFG_SAMPLE_COUNT: count_reg = data[COUNT_BITS-1:0];
			default: ;
		endcase
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_tick(input bit rst, input bit pinned, input bit pin_valid,
			input logic [OUTPUT_BITS-1:0] pin_value, input bit pin_last);
		int gap;
		bit got;
		sample_t s;
		gap = pick_gap(calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rst;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
		if (rst) restarts++;
		predict_tick(rst, got, s);
		if (pinned) begin
			got = pin_valid;
			s.value = pin_value;
			s.last = pin_last;
		end
		if (got) begin
			pending_samples.push_back(s);
			samples_due++;
		end
	endtask

	// wait for the pipeline to empty, including ticks that carry no sample
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected sample %0d last %0b", sample, last);
			end else begin
				head = pending_samples.pop_front();
				samples_checked++;
				if (last) lasts_seen++;
				if (sample !== $signed(head.value) || last !== head.last) begin
					faults++;
					if (faults <= 10)
						$display("sample mismatch: expected %0d last %0b, got %0d last %0b",
							$signed(head.value), head.last, sample, last);
				end
			end
		end
	end

	initial begin
		int gap;
		int run;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && squeeze) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				gap = pick_gap(1'b0);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 12);
			repeat (run) @(posedge clk);
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL");
		$finish;
	end

	initial begin
		bit dirty;
		bit first;
		int base;
		int n;
		int waited;
		logic [CFG_BITS-1:0] v;
		script_row_t row;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_PHASE_STEP;
		cfg_data <= '0;
		in_valid <= 1'b0;
		restart <= 1'b0;
		step_reg = '0;
		amp_reg = '0;
		count_reg = '0;
		phase_acc = '0;
		sample_idx = '0;
		calm = 1'b0;
		held = 1'b0;
		squeeze = 1'b0;
		faults = 0;
		samples_due = 0;
		samples_checked = 0;
		lasts_seen = 0;
		ticks_sent = 0;
		restarts = 0;
		cfg_writes = 0;

		// nothing configured: no sample
		add_known(1'b0, 1'b0, '0, 1'b0);
		add_cfg(CFG_AMPLITUDE, 32'd32767);
		add_cfg(CFG_SAMPLE_COUNT, 32'd5);
		add_cfg(CFG_PHASE_STEP, 32'h4000_0000);
		add_tick(1'b0);
		add_known(1'b0, 1'b1, 16'sd32766, 1'b0);
		add_tick(1'b0);
		add_known(1'b0, 1'b1, -16'sd32767, 1'b0);
		add_tick(1'b0);
		// duration done
		add_known(1'b0, 1'b0, '0, 1'b0);
		add_tick(1'b1);
		add_tick(1'b1);
		add_cfg(CFG_AMPLITUDE, 32'd0);
		add_cfg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
		add_known(1'b1, 1'b1, '0, 1'b0);
		add_known(1'b0, 1'b1, '0, 1'b0);
		add_cfg(CFG_AMPLITUDE, 32'hFFFF_FFFF);
		add_cfg(CFG_SAMPLE_COUNT, 32'd1);
		add_tick(1'b1);
		add_known(1'b0, 1'b0, '0, 1'b0);
		add_cfg(CFG_SPARE, 32'hFFFF_FFFF);
		add_cfg(CFG_SAMPLE_COUNT, 32'hFFFF_FFFF);
		add_cfg(CFG_PHASE_STEP, 32'h8000_0001);
		add_tick(1'b1);
		add_tick(1'b0);
		add_tick(1'b0);
		add_cfg(CFG_SAMPLE_COUNT, 32'd0);
		add_known(1'b1, 1'b0, '0, 1'b0);
		add_known(1'b0, 1'b0, '0, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		dirty = 1'b0;
		for (int k = 0; k < script.size(); k++) begin
			row = script[k];
			if (row.is_cfg) begin
				if (dirty) drain();
				dirty = 1'b0;
				write_reg(row.idx, row.data);
			end else begin
				send_tick(row.rst, row.pinned, row.pin_valid, row.pin_value, row.pin_last);
				dirty = 1'b1;
			end
		end

		base = ticks_sent;
		first = 1'b1;
		while (ticks_sent - base < RANDOM_TICKS) begin
			drain();
			calm = first || ($urandom_range(0, 4) == 0);
			if (first || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = 32'hFFFF_FFFF;
					2: v = 32'd1 << $urandom_range(0, 31);
					3: v = $urandom_range(1, 1947820000);
					default: v = $urandom;
				endcase
				write_reg(CFG_PHASE_STEP, v);
			end
			if (first || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = 32'h7FFF;
					2: v = 32'hFFFF_FFFF;
					3: v = $urandom_range(1, 8);
					default: v = $urandom;
				endcase
				write_reg(CFG_AMPLITUDE, v);
			end
			if (first || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: v = '0;
					1: v = $urandom;
					2: v = 32'hFFFF_FFFF;
					default: v = $urandom_range(1, 48);
				endcase
				// every tick of the stall batch yields a sample
				if (first) v = 32'h00FF_FFFF;
				write_reg(CFG_SAMPLE_COUNT, v);
			end
			if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, $urandom);
			n = first ? 64 : $urandom_range(4, 64);
			if (first) begin
				squeeze = 1'b1;
				wait (held);
			end
			first = 1'b0;
			for (int k = 0; k < n; k++)
				send_tick((k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0),
					1'b0, 1'b0, '0, 1'b0);
		end

		in_valid <= 1'b0;
		waited = 0;
		while (pending_samples.size() != 0 && waited < END_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (pending_samples.size() != 0) begin
			faults += pending_samples.size();
			$display("%0d expected samples never arrived", pending_samples.size());
		end

		$display("Sent %0d ticks (%0d with restart) over %0d register writes;",
			ticks_sent, restarts, cfg_writes);
		$display("checked %0d samples, %0d flagged last, one %0d-cycle output stall.",
			samples_checked, lasts_seen, HOLD_OFF);
		if (faults == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
